// File: hw/rtl/ash_pkg.sv
`default_nettype none
package ash_pkg;

  localparam int AGE_BUCKETS   = 1000;
  localparam int SIZE_BUCKETS  = 12;
  // last age bucket lives in a register, the rest in memory
  localparam int AGE_MEM_DEPTH = AGE_BUCKETS - 1;
  localparam int AGE_IW        = (AGE_MEM_DEPTH > 1) ? $clog2(AGE_MEM_DEPTH) : 1;
  localparam int SIZE_AW       = $clog2(SIZE_BUCKETS);
  localparam int CLR_LEN       = (AGE_MEM_DEPTH > SIZE_BUCKETS) ? AGE_MEM_DEPTH : SIZE_BUCKETS;
  localparam int CLR_W         = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

  localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_SIZE_UNDERRUN = 2'd1,
    ST_AGE_UNDERRUN  = 2'd2,
    ST_BAD_BIRTH     = 2'd3
  } status_code_t;

  typedef struct packed {
    opcode_t     command;
    logic [31:0] block_size;
    logic [31:0] now_seconds;
    logic [31:0] birth_seconds;
    logic [9:0]  bucket_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        time_not_advanced;
    logic [47:0] current_bytes;
    logic [47:0] total_bytes;
    logic [31:0] size_count;
    logic [31:0] age_count;
    logic [31:0] declined_updates;
    logic [31:0] size_underruns;
    logic [31:0] age_underruns;
    logic [31:0] bad_birthdays;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic clr_step;
    logic size_rd;
    logic size_upd;
    logic age_start;
    logic sweep_step;
    logic post_rd;
    logic post_wr;
    logic idx_rd;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic is_alloc;
    logic is_access;
    logic size_fail;
    logic birth_late;
    logic age_run;
    logic sweep_last;
  } ctl_stat_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CNT_MAX : s[31:0];
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? BYTES_MAX : s[47:0];
  endfunction

  // power-of-two size bucket, sizes below four go to bucket zero
  function automatic logic [SIZE_AW-1:0] size_slot(input logic [31:0] sz);
    logic [4:0] msb;
    logic [4:0] slot;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (sz[i]) msb = 5'(i);
    end
    if (sz < 32'd4) slot = '0;
    else slot = msb - 5'd1;
    if (slot > 5'(SIZE_BUCKETS - 1)) slot = 5'(SIZE_BUCKETS - 1);
    return SIZE_AW'(slot);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ash_ctrl.sv
`default_nettype none
module ash_ctrl import ash_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ctl_stat_t stat,
  output ctl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SIZE_RD, S_SIZE_UPD, S_AGE_CHK, S_SWEEP, S_DRAIN,
    S_POST_RD, S_POST_WR, S_IDX_RD, S_OUT
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_SIZE_RD;
        end
      end
      S_SIZE_RD: begin
        if (stat.is_access) begin
          cmd.size_rd = 1'b1;
          state_next  = S_SIZE_UPD;
        end else begin
          state_next = S_IDX_RD;
        end
      end
      S_SIZE_UPD: begin
        cmd.size_upd = 1'b1;
        if (stat.is_alloc) state_next = S_AGE_CHK;
        else if (stat.size_fail || stat.birth_late) state_next = S_IDX_RD;
        else state_next = S_AGE_CHK;
      end
      S_AGE_CHK: begin
        cmd.age_start = 1'b1;
        state_next    = stat.age_run ? S_SWEEP : S_POST_RD;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_POST_RD;
      S_POST_RD: begin
        cmd.post_rd = 1'b1;
        state_next  = S_POST_WR;
      end
      S_POST_WR: begin
        cmd.post_wr = 1'b1;
        state_next  = S_IDX_RD;
      end
      S_IDX_RD: begin
        cmd.idx_rd = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ash_dpath.sv
`default_nettype none
module ash_dpath import ash_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_data,
  input  wire ctl_cmd_t cmd,
  output ctl_stat_t     stat,
  output out_item_t     out_data
);

  // item and scalar state
  in_item_t          item;
  logic [31:0]       last_age_time;
  logic [47:0]       live_bytes;
  logic [47:0]       lifetime_bytes;
  logic [31:0]       declined_count;
  logic [31:0]       size_underrun_count;
  logic [31:0]       age_underrun_count;
  logic [31:0]       birthday_error_count;
  logic [31:0]       age_last;
  logic [1:0]        status;
  logic              declined;

  // stores
  logic [31:0]       age_mem  [AGE_MEM_DEPTH];
  logic [31:0]       size_mem [SIZE_BUCKETS];
  logic [31:0]       rd_a;
  logic [31:0]       rd_b;
  logic [31:0]       sz_rd;

  // sweep and clear
  logic [CLR_W-1:0]  clr;
  logic [AGE_IW-1:0] k;
  logic [AGE_IW-1:0] shift;
  logic [AGE_IW-1:0] j;
  logic              mv;
  logic              acc_hit;
  logic              pend;
  logic              pend_mv;
  logic              pend_acc;
  logic [AGE_IW-1:0] pend_addr;

  logic [SIZE_AW-1:0] slot;
  logic [31:0]        age_diff;
  logic [31:0]        elapsed;
  logic [31:0]        post_tgt;
  logic               tgt_last;
  logic [31:0]        post_cur;
  logic               size_fail;
  logic               is_alloc;

  logic               mem_we;
  logic [AGE_IW-1:0]  mem_waddr;
  logic [31:0]        mem_wdata;
  logic               rd_a_en;
  logic [AGE_IW-1:0]  rd_a_addr;
  logic               sz_we;
  logic [SIZE_AW-1:0] sz_waddr;
  logic [31:0]        sz_wdata;
  logic [SIZE_AW-1:0] sz_raddr;

  assign is_alloc  = (item.command == CMD_ALLOC);
  assign slot      = size_slot(item.block_size);
  assign size_fail = (live_bytes < {16'b0, item.block_size}) || (sz_rd == 32'd0);
  assign age_diff  = item.now_seconds - item.birth_seconds;
  assign elapsed   = item.now_seconds - last_age_time;
  assign post_tgt  = is_alloc ? 32'd0 :
                     (age_diff > 32'(AGE_BUCKETS - 1)) ? 32'(AGE_BUCKETS - 1) : age_diff;
  assign tgt_last  = (post_tgt == 32'(AGE_BUCKETS - 1));
  assign post_cur  = tgt_last ? age_last : rd_a;

  // sweep addressing, destination j pulls from j - shift
  assign j       = AGE_IW'(AGE_MEM_DEPTH - 1) - k;
  assign mv      = (j >= shift);
  assign acc_hit = ({1'b0, j} + {1'b0, shift}) >= (AGE_IW + 1)'(AGE_MEM_DEPTH);

  always_comb begin
    stat.clr_done   = (clr == CLR_W'(CLR_LEN - 1));
    stat.is_alloc   = is_alloc;
    stat.is_access  = (item.command == CMD_ALLOC) || (item.command == CMD_FREE);
    stat.size_fail  = size_fail;
    stat.birth_late = (item.birth_seconds > item.now_seconds);
    stat.age_run    = (item.now_seconds > last_age_time);
    stat.sweep_last = (k == AGE_IW'(AGE_MEM_DEPTH - 1));
  end

  // age memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = pend_mv ? rd_a : 32'd0;
    if (cmd.clr_step) begin
      mem_we    = (32'(clr) < 32'(AGE_MEM_DEPTH));
      mem_waddr = AGE_IW'(clr);
      mem_wdata = 32'd0;
    end else if (pend) begin
      mem_we = 1'b1;
    end else if (cmd.post_wr && !tgt_last) begin
      mem_waddr = AGE_IW'(post_tgt);
      if (is_alloc) begin
        mem_we    = 1'b1;
        mem_wdata = sat_inc32(post_cur);
      end else begin
        mem_we    = (post_cur != 32'd0);
        mem_wdata = post_cur - 32'd1;
      end
    end
    rd_a_en   = cmd.sweep_step || cmd.post_rd || cmd.idx_rd;
    rd_a_addr = AGE_IW'(item.bucket_index);
    if (cmd.sweep_step) rd_a_addr = j - shift;
    else if (cmd.post_rd) rd_a_addr = AGE_IW'(post_tgt);
  end

  always_ff @(posedge clk) begin
    if (mem_we) age_mem[mem_waddr] <= mem_wdata;
    if (rd_a_en) rd_a <= age_mem[rd_a_addr];
    if (cmd.sweep_step) rd_b <= age_mem[j];
  end

  // size memory port selection
  always_comb begin
    sz_we    = 1'b0;
    sz_waddr = slot;
    sz_wdata = sz_rd - 32'd1;
    sz_raddr = cmd.size_rd ? slot : SIZE_AW'(item.bucket_index);
    if (cmd.clr_step) begin
      sz_we    = (32'(clr) < 32'(SIZE_BUCKETS));
      sz_waddr = SIZE_AW'(clr);
      sz_wdata = 32'd0;
    end else if (cmd.size_upd) begin
      if (is_alloc) begin
        sz_we    = 1'b1;
        sz_wdata = sat_inc32(sz_rd);
      end else begin
        sz_we = !size_fail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sz_we) size_mem[sz_waddr] <= sz_wdata;
    if (cmd.size_rd || cmd.idx_rd) sz_rd <= size_mem[sz_raddr];
  end

  // item latch and sweep pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_data;
    if (cmd.sweep_step) begin
      pend_addr <= j;
      pend_mv   <= mv;
      pend_acc  <= acc_hit;
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr                  <= '0;
      k                    <= '0;
      shift                <= '0;
      pend                 <= 1'b0;
      last_age_time        <= '0;
      live_bytes           <= '0;
      lifetime_bytes       <= '0;
      declined_count       <= '0;
      size_underrun_count  <= '0;
      age_underrun_count   <= '0;
      birthday_error_count <= '0;
      age_last             <= '0;
      status               <= ST_OK;
      declined             <= 1'b0;
    end else begin
      pend <= cmd.sweep_step;
      if (cmd.clr_step) clr <= clr + CLR_W'(1);
      if (cmd.load_item) begin
        status   <= ST_OK;
        declined <= 1'b0;
      end
      // byte counters and size checks
      if (cmd.size_upd) begin
        if (is_alloc) begin
          live_bytes     <= sat_add48(live_bytes, item.block_size);
          lifetime_bytes <= sat_add48(lifetime_bytes, item.block_size);
        end else if (size_fail) begin
          size_underrun_count <= sat_inc32(size_underrun_count);
          status              <= ST_SIZE_UNDERRUN;
        end else begin
          live_bytes <= live_bytes - {16'b0, item.block_size};
          if (stat.birth_late) begin
            birthday_error_count <= sat_inc32(birthday_error_count);
            status               <= ST_BAD_BIRTH;
          end
        end
      end
      // aging decision
      if (cmd.age_start) begin
        last_age_time <= item.now_seconds;
        k             <= '0;
        if (!stat.age_run) begin
          declined_count <= sat_inc32(declined_count);
          declined       <= 1'b1;
        end
        shift <= (elapsed > 32'(AGE_MEM_DEPTH)) ? AGE_IW'(AGE_MEM_DEPTH) : AGE_IW'(elapsed);
      end
      if (cmd.sweep_step) k <= k + AGE_IW'(1);
      // overflowing entries collect in the last bucket
      if (pend && pend_acc) age_last <= sat_add32(age_last, rd_b);
      // new or removed entry
      if (cmd.post_wr) begin
        if (is_alloc) begin
          if (tgt_last) age_last <= sat_inc32(age_last);
        end else if (post_cur == 32'd0) begin
          age_underrun_count <= sat_inc32(age_underrun_count);
          status             <= ST_AGE_UNDERRUN;
        end else if (tgt_last) begin
          age_last <= age_last - 32'd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.status            <= status;
      out_data.time_not_advanced <= declined;
      out_data.current_bytes     <= live_bytes;
      out_data.total_bytes       <= lifetime_bytes;
      out_data.size_count        <= ({22'b0, item.bucket_index} < 32'(SIZE_BUCKETS)) ?
                                    sz_rd : 32'd0;
      if ({22'b0, item.bucket_index} < 32'(AGE_MEM_DEPTH)) out_data.age_count <= rd_a;
      else if ({22'b0, item.bucket_index} == 32'(AGE_BUCKETS - 1))
        out_data.age_count <= age_last;
      else out_data.age_count <= 32'd0;
      out_data.declined_updates  <= declined_count;
      out_data.size_underruns    <= size_underrun_count;
      out_data.age_underruns     <= age_underrun_count;
      out_data.bad_birthdays     <= birthday_error_count;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/alloc_size_age_histogram_unit.sv
`default_nettype none
// channel   direction   payload      handshake
// in        input       in_item_t    in_valid / in_stall
// out       output      out_item_t   out_valid / out_stall
//
// read or no-op items go straight to the index read, a rejected free skips aging,
// an item with no elapsed time skips the sweep; items that age the store run the
// one-entry-per-cycle sweep over the age memory (one write port)
// after reset a clearing pass zeroes both stores,
// input stays stalled until it ends
// one item at a time; the next is taken while the result waits in the output register
module alloc_size_age_histogram_unit import ash_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  ash_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ash_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // one item in flight at a time
  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  // clear, size update, sweep, post write and output load commands never coincide
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.size_upd, cmd.sweep_step, cmd.post_wr, cmd.out_load}))
    else $error("conflicting datapath commands");

  // a loaded result is presented
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not valid");

  // sweep ends after its last step
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep_step && stat.sweep_last) |=> !cmd.sweep_step)
    else $error("sweep ran past the last bucket");

endmodule
`default_nettype wire
